/* rtl/core/sobel_edge_magnitude_core_assert.svh */
// assertion macros for the sobel edge magnitude core
`ifndef SOBEL_EDGE_MAGNITUDE_CORE_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_CORE_ASSERT_SVH

// same-cycle implication, muted during reset
`define SOBM_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: lbl failed");

// next-cycle implication, muted during reset
`define SOBM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: lbl failed");

// next-cycle implication, checked also through reset
`define SOBM_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: lbl failed");

`endif

/* rtl/core/sobm_pkg.sv */
package sobm_pkg;

  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 4096;
  localparam int AddrW     = $clog2(MaxWidth);

  typedef logic [7:0]  pix_t;
  typedef logic [11:0] row_t;
  typedef logic [9:0]  col_t;
  typedef logic [10:0] fwidth_t;
  typedef logic [12:0] fheight_t;

  localparam fwidth_t  FwReset = 11'd640;
  localparam fheight_t FhReset = 13'd480;
  localparam fwidth_t  FwMin   = 11'd8;
  localparam fwidth_t  FwMax   = 11'(MaxWidth);
  localparam fheight_t FhMin   = 13'd7;
  localparam fheight_t FhMax   = 13'(MaxHeight);

  localparam logic CfgWidth  = 1'b0;
  localparam logic CfgHeight = 1'b1;

  // one classified request handed from front to back
  typedef struct packed {
    pix_t [8:0] win;
    row_t       row;
    col_t       col;
    pix_t       px;
    logic       has_int;
    logic       has_bord;
    logic       done;
  } qent_t;

  typedef enum logic {F_IDLE, F_READ} front_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_GRAD, B_SQ, B_ROOT, B_EMIT_INT, B_EMIT_BORD
  } back_state_t;

  function automatic logic interior(row_t r, col_t c, fwidth_t w, fheight_t h);
    logic [13:0] r4;
    logic [11:0] c4;
    r4 = {2'b00, r} + 14'd4;
    c4 = {2'b00, c} + 12'd4;
    return (r >= 12'd3) && (r4 <= {1'b0, h}) && (c >= 10'd3) && (c4 <= {1'b0, w});
  endfunction

endpackage

/* rtl/core/sobm_ram.sv */
module sobm_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/sobm_front.sv */
module sobm_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  sobm_pkg::pix_t      pixel_in,
  input  logic                cfg_wr,
  input  logic                cfg_sel,
  input  logic [12:0]         cfg_wdata,
  output logic                q_push,
  output sobm_pkg::qent_t     q_data,
  input  logic                q_full
);
  import sobm_pkg::*;

  front_state_t state, state_next;
  fwidth_t      fw, w_sat;
  fheight_t     fh, h_sat;
  row_t         row, row_r;
  col_t         col, col_r;
  pix_t         px_r;
  logic         has_int_r, has_bord_r, done_r;
  pix_t [8:0]   win, win_next;
  pix_t         up_rd, mid_rd;
  logic         accept, commit;

  always_comb begin
    w_sat = (fw < FwMin) ? FwMin : ((fw > FwMax) ? FwMax : fw);
    h_sat = (fh < FhMin) ? FhMin : ((fh > FhMax) ? FhMax : fh);
  end

  assign in_stall = (state != F_IDLE);
  assign accept   = in_valid && !in_stall;
  assign commit   = (state == F_READ) && !q_full;

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: if (accept) state_next = F_READ;
      F_READ: if (commit) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fw  <= FwReset;
      fh  <= FhReset;
      row <= '0;
      col <= '0;
    end else if (cfg_wr) begin
      if (cfg_sel == CfgWidth) fw <= cfg_wdata[10:0];
      else fh <= cfg_wdata;
      row <= '0;
      col <= '0;
    end else if (accept) begin
      if (({1'b0, col} + 11'd1) >= w_sat) begin
        col <= '0;
        row <= (({1'b0, row} + 13'd1) >= h_sat) ? '0 : row + 12'd1;
      end else begin
        col <= col + 10'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px_r       <= pixel_in;
      row_r      <= row;
      col_r      <= col;
      has_int_r  <= (row != '0) && (col != '0) &&
                    interior(row - 12'd1, col - 10'd1, w_sat, h_sat);
      has_bord_r <= !interior(row, col, w_sat, h_sat);
      done_r     <= (({1'b0, row} + 13'd1) == h_sat) && (({1'b0, col} + 11'd1) == w_sat);
    end
  end

  always_comb begin
    win_next = win;
    for (int k = 0; k < 3; k++) begin
      win_next[k*3]   = win[k*3+1];
      win_next[k*3+1] = win[k*3+2];
    end
    win_next[2] = up_rd;
    win_next[5] = mid_rd;
    win_next[8] = px_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (commit) begin
      win <= win_next;
    end
  end

  sobm_ram #(.Width(8), .Depth(MaxWidth)) u_upper (
    .clk(clk), .we(commit), .waddr(col_r[AddrW-1:0]), .wdata(mid_rd),
    .re(accept), .raddr(col[AddrW-1:0]), .rdata(up_rd)
  );

  sobm_ram #(.Width(8), .Depth(MaxWidth)) u_middle (
    .clk(clk), .we(commit), .waddr(col_r[AddrW-1:0]), .wdata(px_r),
    .re(accept), .raddr(col[AddrW-1:0]), .rdata(mid_rd)
  );

  assign q_push          = commit && (has_int_r || has_bord_r);
  assign q_data.win      = win_next;
  assign q_data.row      = row_r;
  assign q_data.col      = col_r;
  assign q_data.px       = px_r;
  assign q_data.has_int  = has_int_r;
  assign q_data.has_bord = has_bord_r;
  assign q_data.done     = done_r;

endmodule

/* rtl/core/sobm_fifo.sv */
module sobm_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  sobm_pkg::qent_t din,
  output logic            full,
  input  logic            pop,
  output sobm_pkg::qent_t dout,
  output logic            empty
);
  import sobm_pkg::*;

  qent_t      mem [4];
  logic [1:0] wptr, rptr;
  logic [2:0] count;

  assign full  = (count == 3'd4);
  assign empty = (count == 3'd0);
  assign dout  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) mem[wptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push && !full) wptr <= wptr + 2'd1;
      if (pop && !empty) rptr <= rptr + 2'd1;
      count <= count + 3'(push && !full) - 3'(pop && !empty);
    end
  end

endmodule

/* rtl/core/sobm_back.sv */
module sobm_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  sobm_pkg::qent_t q_data,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output sobm_pkg::row_t  pixel_row,
  output sobm_pkg::col_t  pixel_col,
  output sobm_pkg::pix_t  edge_value,
  output logic            is_interior,
  output logic            run_last,
  output logic            frame_done
);
  import sobm_pkg::*;

  back_state_t state, state_next;
  qent_t       ent;
  logic [9:0]  ax, ay;
  logic [15:0] v;
  logic [7:0]  root, mag;
  logic [9:0]  rem;
  logic [2:0]  cnt;
  logic [20:0] s;
  logic signed [11:0] gx, gy;
  logic [11:0] rem_w;
  logic [8:0]  trial;
  logic [7:0]  root_sh;
  logic        out_free, load_int, load_bord;

  assign out_free  = !out_valid || !out_stall;
  assign q_pop     = (state == B_IDLE) && !q_empty;
  assign load_int  = (state == B_EMIT_INT) && out_free;
  assign load_bord = (state == B_EMIT_BORD) && out_free;

  always_comb begin
    gx = (12'(ent.win[2]) + {3'b0, ent.win[5], 1'b0} + 12'(ent.win[8]))
       - (12'(ent.win[0]) + {3'b0, ent.win[3], 1'b0} + 12'(ent.win[6]));
    gy = (12'(ent.win[6]) + {3'b0, ent.win[7], 1'b0} + 12'(ent.win[8]))
       - (12'(ent.win[0]) + {3'b0, ent.win[1], 1'b0} + 12'(ent.win[2]));
    s       = 21'(ax * ax) + 21'(ay * ay);
    root_sh = {root[6:0], 1'b0};
    rem_w   = {rem, v[15:14]};
    trial   = {root_sh, 1'b1};
  end

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:      if (!q_empty) state_next = q_data.has_int ? B_GRAD : B_EMIT_BORD;
      B_GRAD:      state_next = B_SQ;
      B_SQ:        state_next = (s[20:16] != '0) ? B_EMIT_INT : B_ROOT;
      B_ROOT:      if (cnt == 3'd7) state_next = B_EMIT_INT;
      B_EMIT_INT:  if (out_free) state_next = ent.has_bord ? B_EMIT_BORD : B_IDLE;
      B_EMIT_BORD: if (out_free) state_next = B_IDLE;
      default:     state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (!q_empty) ent <= q_data;
      end
      B_GRAD: begin
        ax <= gx[11] ? 10'(-gx) : gx[9:0];
        ay <= gy[11] ? 10'(-gy) : gy[9:0];
      end
      B_SQ: begin
        v    <= s[15:0];
        root <= '0;
        rem  <= '0;
        cnt  <= '0;
        mag  <= 8'd255;
      end
      B_ROOT: begin
        v   <= {v[13:0], 2'b00};
        cnt <= cnt + 3'd1;
        if ({3'b0, trial} <= rem_w) begin
          rem  <= 10'(rem_w - {3'b0, trial});
          root <= root_sh | 8'd1;
          if (cnt == 3'd7) mag <= root_sh | 8'd1;
        end else begin
          rem  <= rem_w[9:0];
          root <= root_sh;
          if (cnt == 3'd7) mag <= root_sh;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_int || load_bord) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_int) begin
      pixel_row   <= ent.row - 12'd1;
      pixel_col   <= ent.col - 10'd1;
      edge_value  <= mag;
      is_interior <= 1'b1;
      run_last    <= !ent.has_bord;
      frame_done  <= 1'b0;
    end else if (load_bord) begin
      pixel_row   <= ent.row;
      pixel_col   <= ent.col;
      edge_value  <= ent.px;
      is_interior <= 1'b0;
      run_last    <= 1'b1;
      frame_done  <= ent.done;
    end
  end

endmodule

/* rtl/core/sobel_edge_magnitude_core.sv */
// sobel edge magnitude core
// input channel: in_valid / in_stall with pixel_in, one pixel per request,
//   raster order; a request is taken when in_valid is high and in_stall low
// output channel: out_valid / out_stall; each request gives zero, one or two
//   results, the delayed interior magnitude first, run_last on the last one
// config: cfg_valid / cfg_ready with cfg_index (0 width, 1 height) and
//   cfg_data; cfg_ready is always high, a write restarts the frame counters
// sequence: the front takes a pixel, reads the line stores, then updates the
//   window before it takes the next pixel, and waits while the queue is full;
//   the back pops, then emits a pass-through result, or pops, computes the
//   gradient and the squares, runs the 8-step root loop and emits a magnitude;
//   a saturating sum of squares skips the root loop and gives a magnitude of 255
// a 4-deep queue between front and back absorbs bursts of border pixels
// reset: counters to zero, width 640, height 480, window cleared, queue
//   emptied; line stores keep their contents
// out_stall holds the result register; the queue then fills and in_stall rises
module sobel_edge_magnitude_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  sobm_pkg::pix_t  pixel_in,
  output logic            out_valid,
  input  logic            out_stall,
  output sobm_pkg::row_t  pixel_row,
  output sobm_pkg::col_t  pixel_col,
  output sobm_pkg::pix_t  edge_value,
  output logic            is_interior,
  output logic            run_last,
  output logic            frame_done,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic            cfg_index,
  input  logic [12:0]     cfg_data
);
  import sobm_pkg::*;

  qent_t q_in, q_out;
  logic  q_push, q_full, q_pop, q_empty;

  assign cfg_ready = 1'b1;

  sobm_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .pixel_in(pixel_in), .cfg_wr(cfg_valid && cfg_ready), .cfg_sel(cfg_index),
    .cfg_wdata(cfg_data), .q_push(q_push), .q_data(q_in), .q_full(q_full)
  );

  sobm_fifo u_fifo (
    .clk(clk), .rst(rst), .push(q_push), .din(q_in), .full(q_full),
    .pop(q_pop), .dout(q_out), .empty(q_empty)
  );

  sobm_back u_back (
    .clk(clk), .rst(rst), .q_empty(q_empty), .q_data(q_out), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall), .pixel_row(pixel_row),
    .pixel_col(pixel_col), .edge_value(edge_value), .is_interior(is_interior),
    .run_last(run_last), .frame_done(frame_done)
  );

endmodule

/* rtl/core/sobm_checker.sv */
`include "sobel_edge_magnitude_core_assert.svh"

module sobm_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [11:0] pixel_row,
  input logic [9:0]  pixel_col,
  input logic        is_interior,
  input logic        run_last,
  input logic        frame_done
);

  `SOBM_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)
  `SOBM_ASSERT_NOW(a_done_last, clk, rst, out_valid && frame_done, run_last && !is_interior)
  `SOBM_ASSERT_NOW(a_int_pos, clk, rst, out_valid && is_interior, (pixel_row >= 12'd3) && (pixel_col >= 10'd3))
  `SOBM_ASSERT_ALWAYS_NEXT(a_rst_quiet, clk, rst, !out_valid)

endmodule

bind sobel_edge_magnitude_core sobm_checker u_sobm_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall),
  .pixel_row(pixel_row), .pixel_col(pixel_col), .is_interior(is_interior),
  .run_last(run_last), .frame_done(frame_done)
);
